// File: rtl/fac_pkg.sv
// Shared types, constants and a helper function of the flash access command splitter.
package fac_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 24;
    localparam int LEN_W      = 9;
    localparam int SECT_W     = 12;
    localparam int KIND_W     = 3;
    localparam int CNT_W      = 6;
    localparam int CHIP_W     = 25;
    localparam int PAGE_W     = 13;
    localparam int SECTB_W    = 17;
    localparam int PROD_W     = SECT_W + SECTB_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // Request limits and burst geometry
    localparam logic [LEN_W:0]   MAX_REQUEST_BYTES = 10'd256;
    localparam int               BURST_SHIFT       = 5;
    localparam logic [CNT_W-1:0] BURST_BYTES       = 6'd32;
    localparam int               MAX_RESULTS       = 24;

    // Request operations
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WREN   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PROG   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES = 2'd2;

    // Configuration reset values
    localparam logic [CHIP_W-1:0]  CHIP_BYTES_RESET   = 25'd4194304;
    localparam logic [PAGE_W-1:0]  PAGE_BYTES_RESET   = 13'd256;
    localparam logic [SECTB_W-1:0] SECTOR_BYTES_RESET = 17'd4096;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [SECT_W-1:0] sector;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] flash_address;
        logic [CNT_W-1:0]  byte_count;
        logic              last;
    } res_t;

    typedef enum logic [2:0] {
        JOB_READ   = 3'd0,
        JOB_WRITE  = 3'd1,
        JOB_ERASE  = 3'd2,
        JOB_DONE   = 3'd3,
        JOB_REJECT = 3'd4
    } job_t;

    // Classified request handed from the front end to the sequencer
    typedef struct packed {
        job_t              job;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } desc_t;

    // Largest power of two not above raw, held between 32 and 4096
    function automatic logic [PAGE_W-1:0] effective_page(input logic [PAGE_W-1:0] raw);
        logic [PAGE_W-1:0] p;
        p = PAGE_W'(32);
        for (int i = 6; i < PAGE_W; i++) begin
            if (raw[i]) begin
                p = PAGE_W'(1) << i;
            end
        end
        return p;
    endfunction

endpackage

// File: rtl/fac_if.sv
// Request and result channel interfaces of the flash access command splitter.
interface fac_req_if;
    logic          valid;
    logic          ready;
    fac_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fac_res_if;
    logic          valid;
    logic          ready;
    fac_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/fac_front.sv
// Front end: accepts requests, checks them and classifies them into descriptors.
module fac_front (
    input  logic                         clk,
    input  logic                         rst_n,
    fac_req_if.sink                      req,
    input  logic [fac_pkg::CHIP_W-1:0]   chip_bytes,
    input  logic [fac_pkg::PAGE_W-1:0]   page_eff,
    input  logic [fac_pkg::SECTB_W-1:0]  sector_bytes,
    output logic                         push_valid,
    input  logic                         push_ready,
    output fac_pkg::desc_t               push_desc
);

    logic                         hold_valid_reg;
    logic                         hold_valid_next;
    fac_pkg::req_t                hold_reg;
    logic [fac_pkg::PROD_W-1:0]   prod_reg;
    logic                         accept;

    logic [fac_pkg::CHIP_W-1:0]   rw_end;
    logic                         too_long;
    logic                         misaligned;
    logic                         out_of_range;
    logic                         is_write;
    logic [fac_pkg::PAGE_W-1:0]   room;
    logic [fac_pkg::LEN_W-1:0]    first_len;
    logic [fac_pkg::LEN_W-1:0]    rest_len;
    logic [4:0]                   head_bursts;
    logic [4:0]                   tail_bursts;
    logic [4:0]                   read_bursts;
    logic [5:0]                   write_bursts;
    logic                         too_many;
    logic [fac_pkg::PROD_W:0]     erase_end;
    logic                         erase_bad;

    // Take a new word whenever the holding stage is empty or drains this cycle
    assign req.ready  = !hold_valid_reg || push_ready;
    assign accept     = req.valid && req.ready;
    assign push_valid = hold_valid_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Capture the request and the erase address product
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= req.data;
            prod_reg <= fac_pkg::PROD_W'(req.data.sector) * fac_pkg::PROD_W'(sector_bytes);
        end
    end

    // Bounds, alignment and command count checks
    always_comb
    begin
        is_write     = hold_reg.operation == fac_pkg::OP_WRITE;
        rw_end       = fac_pkg::CHIP_W'(hold_reg.address) + fac_pkg::CHIP_W'(hold_reg.length);
        too_long     = {1'b0, hold_reg.length} > fac_pkg::MAX_REQUEST_BYTES;
        misaligned   = (hold_reg.length[1:0] != 2'b00) || (hold_reg.address[1:0] != 2'b00);
        out_of_range = rw_end > chip_bytes;
        room         = page_eff - (hold_reg.address[fac_pkg::PAGE_W-1:0]
                                   & (page_eff - fac_pkg::PAGE_W'(1)));
        first_len    = (fac_pkg::PAGE_W'(hold_reg.length) < room)
                       ? hold_reg.length : room[fac_pkg::LEN_W-1:0];
        rest_len     = hold_reg.length - first_len;
        head_bursts  = 5'((10'(first_len) + 10'(fac_pkg::BURST_BYTES - 6'd1))
                          >> fac_pkg::BURST_SHIFT);
        tail_bursts  = 5'((10'(rest_len) + 10'(fac_pkg::BURST_BYTES - 6'd1))
                          >> fac_pkg::BURST_SHIFT);
        read_bursts  = 5'((10'(hold_reg.length) + 10'(fac_pkg::BURST_BYTES - 6'd1))
                          >> fac_pkg::BURST_SHIFT);
        write_bursts = 6'(head_bursts) + 6'(tail_bursts);
        too_many     = is_write ? (write_bursts > 6'(fac_pkg::MAX_RESULTS / 2))
                                : (6'(read_bursts) > 6'(fac_pkg::MAX_RESULTS));
        erase_end    = (fac_pkg::PROD_W + 1)'(prod_reg) + (fac_pkg::PROD_W + 1)'(sector_bytes);
        erase_bad    = (sector_bytes == '0)
                       || (erase_end > (fac_pkg::PROD_W + 1)'(chip_bytes))
                       || (prod_reg[11:0] != 12'h000);
    end

    // Classify the held request
    always_comb
    begin
        push_desc.job     = fac_pkg::JOB_REJECT;
        push_desc.address = '0;
        push_desc.length  = '0;
        case (hold_reg.operation)
            fac_pkg::OP_READ, fac_pkg::OP_WRITE:
            begin
                if (too_long || (is_write && misaligned) || out_of_range)
                begin
                    push_desc.job = fac_pkg::JOB_REJECT;
                end
                else if (hold_reg.length == '0)
                begin
                    push_desc.job = fac_pkg::JOB_DONE;
                end
                else if (too_many)
                begin
                    push_desc.job = fac_pkg::JOB_REJECT;
                end
                else
                begin
                    push_desc.job     = is_write ? fac_pkg::JOB_WRITE : fac_pkg::JOB_READ;
                    push_desc.address = hold_reg.address;
                    push_desc.length  = hold_reg.length;
                end
            end
            fac_pkg::OP_ERASE:
            begin
                if (!erase_bad)
                begin
                    push_desc.job     = fac_pkg::JOB_ERASE;
                    push_desc.address = prod_reg[fac_pkg::ADDR_W-1:0];
                end
            end
            default:
            begin
                push_desc.job = fac_pkg::JOB_REJECT;
            end
        endcase
    end

endmodule

// File: rtl/fac_queue.sv
// Small register queue of classified requests between front end and sequencer.
module fac_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  fac_pkg::desc_t push_desc,
    output logic           pop_valid,
    input  logic           pop_ready,
    output fac_pkg::desc_t pop_desc
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fac_pkg::desc_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_desc   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// File: rtl/fac_back.sv
// Back end: sequences one request into flash commands, one per cycle unless stalled.
module fac_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  fac_pkg::desc_t              pop_desc,
    input  logic [fac_pkg::PAGE_W-1:0]  page_eff,
    fac_res_if.source                   res
);

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_READ       = 8'b0000_0010,
        ST_WREN_PROG  = 8'b0000_0100,
        ST_PROG       = 8'b0000_1000,
        ST_WREN_ERASE = 8'b0001_0000,
        ST_ERASE      = 8'b0010_0000,
        ST_DONE       = 8'b0100_0000,
        ST_REJECT     = 8'b1000_0000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [fac_pkg::ADDR_W-1:0]    addr_reg;
    logic [fac_pkg::ADDR_W-1:0]    addr_next;
    logic [fac_pkg::LEN_W-1:0]     rem_reg;
    logic [fac_pkg::LEN_W-1:0]     rem_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    fac_pkg::res_t                 out_reg;
    fac_pkg::res_t                 out_next;
    logic                          out_free;
    logic [fac_pkg::PAGE_W-1:0]    room;
    logic [fac_pkg::CNT_W-1:0]     read_step;
    logic [fac_pkg::CNT_W-1:0]     prog_step;

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;
    assign out_free  = !out_valid_reg || res.ready;

    // Burst size: remaining bytes capped by the burst and, for programs, the page end
    always_comb
    begin
        room      = page_eff - (addr_reg[fac_pkg::PAGE_W-1:0] & (page_eff - fac_pkg::PAGE_W'(1)));
        read_step = (rem_reg < fac_pkg::LEN_W'(fac_pkg::BURST_BYTES))
                    ? rem_reg[fac_pkg::CNT_W-1:0] : fac_pkg::BURST_BYTES;
        prog_step = (fac_pkg::PAGE_W'(read_step) > room)
                    ? room[fac_pkg::CNT_W-1:0] : read_step;
    end

    // Sequence commands into the output register
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        pop_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    addr_next = pop_desc.address;
                    rem_next  = pop_desc.length;
                    case (pop_desc.job)
                        fac_pkg::JOB_READ:  state_next = ST_READ;
                        fac_pkg::JOB_WRITE: state_next = ST_WREN_PROG;
                        fac_pkg::JOB_ERASE: state_next = ST_WREN_ERASE;
                        fac_pkg::JOB_DONE:  state_next = ST_DONE;
                        default:            state_next = ST_REJECT;
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.kind          = fac_pkg::KIND_READ;
                    out_next.flash_address = addr_reg;
                    out_next.byte_count    = read_step;
                    out_next.last          = rem_reg == fac_pkg::LEN_W'(read_step);
                    addr_next              = addr_reg + fac_pkg::ADDR_W'(read_step);
                    rem_next               = rem_reg - fac_pkg::LEN_W'(read_step);
                    if (rem_reg == fac_pkg::LEN_W'(read_step))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WREN_PROG, ST_WREN_ERASE:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.kind          = fac_pkg::KIND_WREN;
                    out_next.flash_address = '0;
                    out_next.byte_count    = '0;
                    out_next.last          = 1'b0;
                    state_next = (state_reg == ST_WREN_PROG) ? ST_PROG : ST_ERASE;
                end
            end
            ST_PROG:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.kind          = fac_pkg::KIND_PROG;
                    out_next.flash_address = addr_reg;
                    out_next.byte_count    = prog_step;
                    out_next.last          = rem_reg == fac_pkg::LEN_W'(prog_step);
                    addr_next              = addr_reg + fac_pkg::ADDR_W'(prog_step);
                    rem_next               = rem_reg - fac_pkg::LEN_W'(prog_step);
                    state_next = (rem_reg == fac_pkg::LEN_W'(prog_step)) ? ST_IDLE : ST_WREN_PROG;
                end
            end
            ST_ERASE:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.kind          = fac_pkg::KIND_ERASE;
                    out_next.flash_address = addr_reg;
                    out_next.byte_count    = '0;
                    out_next.last          = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_DONE, ST_REJECT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.kind          = (state_reg == ST_DONE) ? fac_pkg::KIND_DONE
                                                                    : fac_pkg::KIND_REJECT;
                    out_next.flash_address = '0;
                    out_next.byte_count    = '0;
                    out_next.last          = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the command cursor and the output word
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        rem_reg  <= rem_next;
        out_reg  <= out_next;
    end

endmodule

// File: rtl/flash_access_command_splitter.sv
// Top level of the flash access command splitter: configuration and channel wiring.
//
// Requests (read, write or sector erase) arrive on the req channel and are
// taken at a clock edge where valid and ready are both high. Each request
// yields a run of SPI flash command words on the res channel (write enable,
// page program, read burst, sector erase, done or rejected); the final word
// of a request has last set.
// The front end checks and classifies a request in the cycle after it is
// taken and pushes it into a small queue; the sequencer pops it into its
// cursor registers, then emits one command word per cycle into an output
// register while that register is free, and finishes one request before it
// pops the next. The longest write is 18 words (nine bursts). The front end
// keeps taking requests while the queue has room.
// When the receiver stalls, the output word holds and the sequencer waits;
// the queue then fills and req.ready drops. Reset clears the queue, the
// sequencer and the output valid, and returns the chip, page and sector
// sizes to 4 MiB, 256 and 4096 bytes. Configuration is to be written by the
// user via cfg_we / cfg_index / cfg_data only while idle; the block has no check.
module flash_access_command_splitter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fac_pkg::CFG_DATA_W-1:0]    cfg_data,
    fac_req_if.sink                           req,
    fac_res_if.source                         res
);

    logic [fac_pkg::CHIP_W-1:0]  chip_bytes_reg;
    logic [fac_pkg::PAGE_W-1:0]  page_eff_reg;
    logic [fac_pkg::SECTB_W-1:0] sector_bytes_reg;

    logic           push_valid;
    logic           push_ready;
    fac_pkg::desc_t push_desc;
    logic           pop_valid;
    logic           pop_ready;
    fac_pkg::desc_t pop_desc;

    // Write configuration registers; keep the page size already rounded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_bytes_reg   <= fac_pkg::CHIP_BYTES_RESET;
            page_eff_reg     <= fac_pkg::PAGE_BYTES_RESET;
            sector_bytes_reg <= fac_pkg::SECTOR_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fac_pkg::CFG_CHIP_BYTES:
                    chip_bytes_reg <= cfg_data[fac_pkg::CHIP_W-1:0];
                fac_pkg::CFG_PAGE_BYTES:
                    page_eff_reg <= fac_pkg::effective_page(cfg_data[fac_pkg::PAGE_W-1:0]);
                fac_pkg::CFG_SECTOR_BYTES:
                    sector_bytes_reg <= cfg_data[fac_pkg::SECTB_W-1:0];
                default:
                    chip_bytes_reg <= chip_bytes_reg;
            endcase
        end
    end

    fac_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .chip_bytes   (chip_bytes_reg),
        .page_eff     (page_eff_reg),
        .sector_bytes (sector_bytes_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_desc    (push_desc)
    );

    fac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    fac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .page_eff  (page_eff_reg),
        .res       (res)
    );

endmodule

// File: rtl/fac_checker.sv
// Port-level assertions for the flash access command splitter, bound to the top level.
module fac_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_ready,
    input fac_pkg::res_t res_data
);

    // No result word while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result word changed");

    // Non-data commands carry no byte count
    a_no_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind != fac_pkg::KIND_READ && res_data.kind != fac_pkg::KIND_PROG
        |-> res_data.byte_count == '0)
        else $error("byte count on a non-data command");

    // Data bursts move between one byte and one burst
    a_burst_size: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.kind == fac_pkg::KIND_READ || res_data.kind == fac_pkg::KIND_PROG)
        |-> res_data.byte_count != '0 && res_data.byte_count <= fac_pkg::BURST_BYTES)
        else $error("burst size out of range");

    // Erase, done and reject end a request; a write enable never does
    a_last_rule: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_data.kind == fac_pkg::KIND_ERASE || res_data.kind == fac_pkg::KIND_DONE
                        || res_data.kind == fac_pkg::KIND_REJECT) ? res_data.last
                       : (res_data.kind == fac_pkg::KIND_WREN) ? !res_data.last : 1'b1))
        else $error("last flag wrong for command kind");

endmodule

bind flash_access_command_splitter fac_checker u_fac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);

// File: bench/testbench.sv
// Self-checking bench for the flash access command splitter: directed and random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 5000;
    localparam logic [fac_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we    = 1'b0;
    logic [fac_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fac_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    fac_req_if req_ch ();
    fac_res_if res_ch ();

    // Shadow of the size registers as last written; the page size is kept unrounded
    logic [fac_pkg::CHIP_W-1:0]  chip_cap   = fac_pkg::CHIP_BYTES_RESET;
    logic [fac_pkg::PAGE_W-1:0]  page_raw   = fac_pkg::PAGE_BYTES_RESET;
    logic [fac_pkg::SECTB_W-1:0] erase_unit = fac_pkg::SECTOR_BYTES_RESET;

    fac_pkg::req_t request_backlog[$];
    fac_pkg::res_t awaited_cmds[$];
    fac_pkg::res_t head_cmd;

    bit calm         = 1'b0;
    int send_wait    = 0;
    int take_wait    = 0;
    int quiet_cycles = 0;
    int fail_count   = 0;

    flash_access_command_splitter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    // Clock and initial levels
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        forever #2 clk = ~clk;
    end

    // Work out the command words one request should produce
    function automatic void split_request(input fac_pkg::req_t r);
        fac_pkg::res_t   run[$];
        longint unsigned a;
        longint unsigned s;
        longint unsigned n;
        longint unsigned piece;
        longint unsigned room;
        longint unsigned span;
        longint unsigned sect_no;
        longint unsigned base;
        bit              reject;
        reject  = 1'b0;
        a       = r.address;
        s       = r.length;
        sect_no = r.sector;
        if (r.operation == fac_pkg::OP_READ || r.operation == fac_pkg::OP_WRITE)
        begin
            if (s > fac_pkg::MAX_REQUEST_BYTES)
                reject = 1'b1;
            else if (r.operation == fac_pkg::OP_WRITE && (s[1:0] != 2'b00 || a[1:0] != 2'b00))
                reject = 1'b1;
            else if (a + s > chip_cap)
                reject = 1'b1;
            else if (s == 0)
                run.push_back('{fac_pkg::KIND_DONE, '0, '0, 1'b0});
            else if (r.operation == fac_pkg::OP_READ)
            begin
                while (s > 0)
                begin
                    n = (s >= fac_pkg::BURST_BYTES) ? fac_pkg::BURST_BYTES : s;
                    run.push_back('{fac_pkg::KIND_READ, a[fac_pkg::ADDR_W-1:0],
                                    n[fac_pkg::CNT_W-1:0], 1'b0});
                    a += n;
                    s -= n;
                end
            end
            else
            begin
                // odd page sizes round down to a power of two, held in 32..4096
                span = 32;
                while (span < 4096 && span * 2 <= page_raw)
                    span = span * 2;
                while (s > 0)
                begin
                    room  = span - (a & (span - 1));
                    piece = (s < room) ? s : room;
                    s -= piece;
                    while (piece > 0)
                    begin
                        n = (piece >= fac_pkg::BURST_BYTES) ? fac_pkg::BURST_BYTES : piece;
                        run.push_back('{fac_pkg::KIND_WREN, '0, '0, 1'b0});
                        run.push_back('{fac_pkg::KIND_PROG, a[fac_pkg::ADDR_W-1:0],
                                        n[fac_pkg::CNT_W-1:0], 1'b0});
                        a     += n;
                        piece -= n;
                    end
                end
            end
        end
        else if (r.operation == fac_pkg::OP_ERASE)
        begin
            if (erase_unit == 0 || sect_no >= chip_cap / erase_unit)
                reject = 1'b1;
            else
            begin
                base = sect_no * erase_unit;
                if (base[11:0] != 12'h000)
                    reject = 1'b1;
                else
                begin
                    run.push_back('{fac_pkg::KIND_WREN, '0, '0, 1'b0});
                    run.push_back('{fac_pkg::KIND_ERASE, base[fac_pkg::ADDR_W-1:0], '0, 1'b0});
                end
            end
        end
        else
            reject = 1'b1;

        if (reject || run.size() > fac_pkg::MAX_RESULTS)
        begin
            run.delete();
            run.push_back('{fac_pkg::KIND_REJECT, '0, '0, 1'b0});
        end
        run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            awaited_cmds.push_back(run[i]);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Build one random request, shaped by the current sizes
    function automatic fac_pkg::req_t make_request();
        fac_pkg::req_t   r;
        int unsigned     roll;
        longint unsigned top;
        longint unsigned sectors;
        r    = '0;
        top  = chip_cap;
        roll = $urandom_range(0, 99);
        if (roll < 44)
            r.operation = fac_pkg::OP_READ;
        else if (roll < 84)
            r.operation = fac_pkg::OP_WRITE;
        else if (roll < 97)
            r.operation = fac_pkg::OP_ERASE;
        else
            r.operation = OP_UNKNOWN;

        // length: empty, full, overlong or ordinary
        roll = $urandom_range(0, 99);
        if (roll < 8)
            r.length = '0;
        else if (roll < 20)
            r.length = fac_pkg::LEN_W'(fac_pkg::MAX_REQUEST_BYTES);
        else if (roll < 25)
            r.length = fac_pkg::LEN_W'($urandom_range(257, 511));
        else if (roll < 60)
            r.length = fac_pkg::LEN_W'($urandom_range(1, 32));
        else
            r.length = fac_pkg::LEN_W'($urandom_range(1, 255));

        // address: anywhere, against the top of the chip, near a 4K line, or inside
        roll = $urandom_range(0, 99);
        if (roll < 10)
            r.address = fac_pkg::ADDR_W'($urandom);
        else if (roll < 30)
            r.address = fac_pkg::ADDR_W'(top - $urandom_range(0, 300));
        else if (roll < 50)
            r.address = fac_pkg::ADDR_W'(($urandom_range(0, 32'(top - 1)) | 32'hFFF)
                                         - $urandom_range(0, 40));
        else
            r.address = fac_pkg::ADDR_W'($urandom_range(0, 32'(top - 1)));

        // keep most writes aligned so they get past the checks
        if (r.operation == fac_pkg::OP_WRITE && $urandom_range(0, 9) != 0)
        begin
            r.address[1:0] = 2'b00;
            r.length[1:0]  = 2'b00;
        end

        sectors = (erase_unit != 0) ? top / erase_unit : 0;
        if (sectors > 4096)
            sectors = 4096;
        if (sectors > 0 && $urandom_range(0, 3) != 0)
            r.sector = fac_pkg::SECT_W'($urandom_range(0, 32'(sectors - 1)));
        else
            r.sector = fac_pkg::SECT_W'($urandom);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        fail_count++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Request driver: predict on acceptance, then present the next word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            send_wait = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                split_request(req_ch.data);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_backlog.size() > 0)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= request_backlog.pop_front();
                    send_wait = calm ? 0 : draw_gap();
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each word with the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            take_wait = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_cmds.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: unexpected word, expected none, ",
                              "got kind %0d addr 0x%0h count %0d last %0d"},
                             $time, res_ch.data.kind, res_ch.data.flash_address,
                             res_ch.data.byte_count, res_ch.data.last);
                end
                else
                begin
                    head_cmd = awaited_cmds.pop_front();
                    if (res_ch.data.kind != head_cmd.kind)
                        flag_mismatch("kind", head_cmd.kind, res_ch.data.kind);
                    if (res_ch.data.flash_address != head_cmd.flash_address)
                        flag_mismatch("flash_address", head_cmd.flash_address,
                                      res_ch.data.flash_address);
                    if (res_ch.data.byte_count != head_cmd.byte_count)
                        flag_mismatch("byte_count", head_cmd.byte_count,
                                      res_ch.data.byte_count);
                    if (res_ch.data.last != head_cmd.last)
                        flag_mismatch("last", head_cmd.last, res_ch.data.last);
                end
            end
            if (take_wait > 0)
            begin
                take_wait--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    take_wait = draw_gap();
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold until every request is sent and every word is back, then let the pipe settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || req_ch.valid || awaited_cmds.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [fac_pkg::CFG_IDX_W-1:0] idx,
                           input longint unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= fac_pkg::CFG_DATA_W'(value);
        case (idx)
            fac_pkg::CFG_CHIP_BYTES:   chip_cap   = fac_pkg::CHIP_W'(value);
            fac_pkg::CFG_PAGE_BYTES:   page_raw   = fac_pkg::PAGE_W'(value);
            fac_pkg::CFG_SECTOR_BYTES: erase_unit = fac_pkg::SECTB_W'(value);
            default: ;
        endcase
    endtask

    task automatic load_sizes(input longint unsigned chip, input longint unsigned page,
                              input longint unsigned sect);
        wait_drained();
        set_reg(fac_pkg::CFG_CHIP_BYTES, chip);
        set_reg(fac_pkg::CFG_PAGE_BYTES, page);
        set_reg(fac_pkg::CFG_SECTOR_BYTES, sect);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic post_request(input logic [fac_pkg::OP_W-1:0] op,
                                input logic [fac_pkg::ADDR_W-1:0] addr,
                                input logic [fac_pkg::LEN_W-1:0] len,
                                input logic [fac_pkg::SECT_W-1:0] sect);
        request_backlog.push_back('{op, addr, len, sect});
    endtask

    // Feed random requests in chunks, draining between chunks
    task automatic feed_random(input int count);
        int left;
        int chunk;
        left = count;
        while (left > 0)
        begin
            chunk = $urandom_range(10, 30);
            if (chunk > left)
                chunk = left;
            @(negedge clk);
            calm = ($urandom_range(0, 3) == 0);
            repeat (chunk) request_backlog.push_back(make_request());
            left -= chunk;
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests at the reset sizes (4 MiB chip, 256-byte page, 4K sector)
        post_request(fac_pkg::OP_READ,  24'h000000, 9'd0,   12'd0);
        post_request(fac_pkg::OP_WRITE, 24'h000000, 9'd0,   12'd0);
        post_request(fac_pkg::OP_READ,  24'hFFFFFF, 9'd0,   12'd0);
        post_request(fac_pkg::OP_READ,  24'h400000, 9'd0,   12'd0);
        post_request(fac_pkg::OP_READ,  24'h3FFFFF, 9'd1,   12'd0);
        post_request(fac_pkg::OP_READ,  24'h000123, 9'd256, 12'd0);
        post_request(fac_pkg::OP_READ,  24'h00001E, 9'd40,  12'd0);
        post_request(fac_pkg::OP_READ,  24'h000000, 9'd257, 12'd0);
        post_request(fac_pkg::OP_READ,  24'h000000, 9'd511, 12'd0);
        post_request(fac_pkg::OP_WRITE, 24'h000000, 9'd256, 12'd0);
        post_request(fac_pkg::OP_WRITE, 24'h0000FC, 9'd256, 12'd0);
        post_request(fac_pkg::OP_WRITE, 24'h000002, 9'd4,   12'd0);
        post_request(fac_pkg::OP_WRITE, 24'h000000, 9'd6,   12'd0);
        post_request(fac_pkg::OP_WRITE, 24'h3FFFFC, 9'd4,   12'd0);
        post_request(fac_pkg::OP_WRITE, 24'h3FFFFC, 9'd8,   12'd0);
        post_request(fac_pkg::OP_WRITE, 24'h000000, 9'd260, 12'd0);
        post_request(fac_pkg::OP_ERASE, 24'h000000, 9'd0,   12'd0);
        post_request(fac_pkg::OP_ERASE, 24'h000000, 9'd0,   12'd1023);
        post_request(fac_pkg::OP_ERASE, 24'h000000, 9'd0,   12'd1024);
        post_request(fac_pkg::OP_ERASE, 24'hFFFFFF, 9'd511, 12'd4095);
        post_request(OP_UNKNOWN, 24'h000040, 9'd32, 12'd5);
        wait_drained();

        feed_random(50);

        // 16 MiB chip (whole 24-bit address space), smallest page, 64K sector
        load_sizes(16777216, 32, 65536);
        feed_random(60);
        // Smallest chip, largest page
        load_sizes(4096, 4096, 4096);
        feed_random(50);
        // Full 25-bit chip size lets addresses wrap; odd page and one-and-a-half-4K sector
        load_sizes(33554431, 100, 6144);
        feed_random(60);
        // Uneven chip size, page above the cap, zero sector size
        load_sizes(1000000, 8191, 0);
        feed_random(50);
        // Zero page size and the widest sector value
        load_sizes(4194304, 0, 131071);
        feed_random(50);
        // Back to a common part with a three-4K sector
        load_sizes(4194304, 256, 12288);
        feed_random(40);

        wait_drained();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
